### hdl/bis_pkg.sv
// Package for the bilinear image scaler: sizes, fixed-point widths, register
// indexes and the control/status structs shared by controller and datapath.
// No dependencies.
package bis_pkg;

  // Source image capacity and fixed-point format
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 8;

  // Field widths
  localparam int COORD_BITS  = 11;
  localparam int CHAN_BITS   = 8;
  localparam int PIXEL_BITS  = 3 * CHAN_BITS;
  localparam int SCALE_BITS  = 10;
  localparam int DIM_BITS    = 9;
  localparam int SIZE_BITS   = 12;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 10;

  // Percent base and derived coordinate widths
  localparam int PCT       = 100;
  localparam int NUM_BITS  = COORD_BITS + $clog2(PCT) + FRAC_BITS;
  localparam int IDX_BITS  = NUM_BITS - FRAC_BITS + 1;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int WT_BITS   = FRAC_BITS + 1;
  localparam int W_BITS    = 2 * FRAC_BITS + 1;
  localparam int ACC_BITS  = CHAN_BITS + W_BITS;
  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS = $clog2(MEM_DEPTH);
  localparam int STEP_CNT_BITS = $clog2(NUM_BITS + 1);

  // Scaled size: (dim * scale + PCT/2) / PCT by reciprocal multiply
  localparam int SPROD_BITS  = DIM_BITS + SCALE_BITS + 1;
  localparam int RECIP_SHIFT = 27;
  localparam longint RECIP   = ((64'd1 << RECIP_SHIFT) + PCT - 1) / PCT;
  localparam int RECIP_BITS  = 21;
  localparam int RPROD_BITS  = SPROD_BITS + RECIP_BITS;
  localparam int SIZE_MAX    = (1 << SIZE_BITS) - 1;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

  // Commands on the input word
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic       store;     // write the input pixel
    logic       load;      // latch coordinates and start the dividers
    logic       div_step;  // one divider iteration
    logic       chk;       // latch weights and inside flag, clear sums
    logic [1:0] rd_sel;    // neighbor being addressed
    logic       mac_en;    // accumulate the pixel read last cycle
    logic [1:0] mac_sel;   // neighbor whose data is on the read port
    logic       out_load;  // load the output register
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_src;
  } sts_t;

endpackage

### hdl/bilinear_image_scaler_top.sv
// Bilinear image scaler: source pixel store and interpolated output pixels.
// Input words carry a command: store writes one BGR source pixel at
// (row, col); compute returns one output word for output (row, col).
// Configuration (scale_percent, src_width, src_height) is written through
// cfg_wr_en/cfg_index/cfg_data while the block is idle.
// A store word is written as it is accepted and produces no output word.
// A compute word runs through the two lane divider, one quotient bit per step
// (26 steps), then latches the weights, makes four reads of the single-port
// pixel memory and finishes the blend, then hands off; a pixel outside the
// source skips the reads and the blend.
// One word is worked on at a time; in_ready is high only when idle, so a new
// word is taken only after the current compute has handed off its result.
// A finished word waits in the output register while the next input is
// taken; if the receiver stalls, the next compute holds at its end until
// the register frees. Reset (rst_n low, synchronous) empties the output,
// returns to idle and restores the registers to 100 %, 256 x 256. The
// pixel memory is not cleared; unwritten pixels read as undefined.
// Depends on bis_pkg, bis_ctrl, bis_dp and bis_div.
module bilinear_image_scaler_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bis_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bis_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [bis_pkg::COORD_BITS-1:0]     in_row,
  input  logic [bis_pkg::COORD_BITS-1:0]     in_col,
  input  logic [bis_pkg::CHAN_BITS-1:0]      in_blue_in,
  input  logic [bis_pkg::CHAN_BITS-1:0]      in_green_in,
  input  logic [bis_pkg::CHAN_BITS-1:0]      in_red_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bis_pkg::CHAN_BITS-1:0]      out_blue_out,
  output logic [bis_pkg::CHAN_BITS-1:0]      out_green_out,
  output logic [bis_pkg::CHAN_BITS-1:0]      out_red_out,
  output logic                               out_inside_res,
  output logic [bis_pkg::SIZE_BITS-1:0]      out_out_width,
  output logic [bis_pkg::SIZE_BITS-1:0]      out_out_height
);
  import bis_pkg::*;

  ctl_t ctl;
  sts_t sts;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  bis_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_blue_in     (in_blue_in),
    .in_green_in    (in_green_in),
    .in_red_in      (in_red_in),
    .ctl            (ctl),
    .sts            (sts),
    .out_blue_out   (out_blue_out),
    .out_green_out  (out_green_out),
    .out_red_out    (out_red_out),
    .out_inside_res (out_inside_res),
    .out_out_width  (out_out_width),
    .out_out_height (out_out_height)
  );

endmodule

### hdl/bis_div.sv
// One lane of the source-coordinate divider: restoring division, one
// quotient bit per step. Depends on bis_pkg.
module bis_div (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [bis_pkg::NUM_BITS-1:0]   num_in,
  input  logic [bis_pkg::SCALE_BITS-1:0] divisor,
  output logic [bis_pkg::NUM_BITS-1:0]   quo
);
  import bis_pkg::*;

  logic [NUM_BITS-1:0]   num_r, num_nxt;
  logic [SCALE_BITS-1:0] rem_r, rem_nxt;
  logic [SCALE_BITS:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, num_r[NUM_BITS-1]};
    num_nxt = num_r;
    rem_nxt = rem_r;
    if (load) begin
      num_nxt = num_in;
      rem_nxt = '0;
    end else if (step) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = SCALE_BITS'(trial - {1'b0, divisor});
        num_nxt = {num_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[SCALE_BITS-1:0];
        num_nxt = {num_r[NUM_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign quo = num_r;

endmodule

### hdl/bis_dp.sv
// Datapath of the bilinear image scaler: configuration registers, pixel
// memory, coordinate dividers, weights, blend sums, size and output words.
// Depends on bis_pkg and bis_div.
module bis_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bis_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bis_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [bis_pkg::COORD_BITS-1:0]     in_row,
  input  logic [bis_pkg::COORD_BITS-1:0]     in_col,
  input  logic [bis_pkg::CHAN_BITS-1:0]      in_blue_in,
  input  logic [bis_pkg::CHAN_BITS-1:0]      in_green_in,
  input  logic [bis_pkg::CHAN_BITS-1:0]      in_red_in,
  input  bis_pkg::ctl_t                      ctl,
  output bis_pkg::sts_t                      sts,
  output logic [bis_pkg::CHAN_BITS-1:0]      out_blue_out,
  output logic [bis_pkg::CHAN_BITS-1:0]      out_green_out,
  output logic [bis_pkg::CHAN_BITS-1:0]      out_red_out,
  output logic                               out_inside_res,
  output logic [bis_pkg::SIZE_BITS-1:0]      out_out_width,
  output logic [bis_pkg::SIZE_BITS-1:0]      out_out_height
);
  import bis_pkg::*;

  // Configuration registers
  logic [SCALE_BITS-1:0] scale_r;
  logic [DIM_BITS-1:0]   width_r;
  logic [DIM_BITS-1:0]   height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_BITS'(PCT);
      width_r  <= DIM_BITS'(MAX_WIDTH);
      height_r <= DIM_BITS'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCALE:  scale_r  <= cfg_data[SCALE_BITS-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[DIM_BITS-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Scaled size: product stage, then reciprocal stage with saturation
  logic [SPROD_BITS-1:0] sprod_w_r, sprod_h_r;
  logic [RPROD_BITS-1:0] rprod_w, rprod_h;
  logic [RPROD_BITS-RECIP_SHIFT-1:0] q_w, q_h;
  logic [SIZE_BITS-1:0]  size_w_r, size_h_r;

  always_ff @(posedge clk) begin
    sprod_w_r <= SPROD_BITS'(width_r) * SPROD_BITS'(scale_r) + SPROD_BITS'(PCT / 2);
    sprod_h_r <= SPROD_BITS'(height_r) * SPROD_BITS'(scale_r) + SPROD_BITS'(PCT / 2);
  end

  assign rprod_w = RPROD_BITS'(sprod_w_r) * RPROD_BITS'(RECIP);
  assign rprod_h = RPROD_BITS'(sprod_h_r) * RPROD_BITS'(RECIP);
  assign q_w     = rprod_w[RPROD_BITS-1:RECIP_SHIFT];
  assign q_h     = rprod_h[RPROD_BITS-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    size_w_r <= (q_w > (RPROD_BITS-RECIP_SHIFT)'(SIZE_MAX)) ? SIZE_BITS'(SIZE_MAX)
                                                           : SIZE_BITS'(q_w);
    size_h_r <= (q_h > (RPROD_BITS-RECIP_SHIFT)'(SIZE_MAX)) ? SIZE_BITS'(SIZE_MAX)
                                                           : SIZE_BITS'(q_h);
  end

  // Source position = idx * 100 * 2^FRAC_BITS / scale, zero scale acts as one
  logic [SCALE_BITS-1:0] divisor;
  logic [NUM_BITS-1:0]   num_row, num_col, quo_row, quo_col;

  assign divisor = (scale_r == '0) ? SCALE_BITS'(1) : scale_r;
  assign num_row = (NUM_BITS'(in_row) * NUM_BITS'(PCT)) << FRAC_BITS;
  assign num_col = (NUM_BITS'(in_col) * NUM_BITS'(PCT)) << FRAC_BITS;

  bis_div u_div_row (
    .clk     (clk),
    .load    (ctl.load),
    .step    (ctl.div_step),
    .num_in  (num_row),
    .divisor (divisor),
    .quo     (quo_row)
  );

  bis_div u_div_col (
    .clk     (clk),
    .load    (ctl.load),
    .step    (ctl.div_step),
    .num_in  (num_col),
    .divisor (divisor),
    .quo     (quo_col)
  );

  // Inside test: both base+1 indexes below the effective size
  logic [IDX_BITS-1:0] r0p1, c0p1;
  logic                in_src;

  assign r0p1   = IDX_BITS'(quo_row[NUM_BITS-1:FRAC_BITS]) + IDX_BITS'(1);
  assign c0p1   = IDX_BITS'(quo_col[NUM_BITS-1:FRAC_BITS]) + IDX_BITS'(1);
  assign in_src = (c0p1 < IDX_BITS'(width_r))  && (c0p1 < IDX_BITS'(MAX_WIDTH)) &&
                  (r0p1 < IDX_BITS'(height_r)) && (r0p1 < IDX_BITS'(MAX_HEIGHT));
  assign sts.in_src = in_src;

  // Neighbor weights, indexed {row step, col step}
  logic [FRAC_BITS-1:0] fr, fc;
  logic [WT_BITS-1:0]   fr_w, fc_w, omfr, omfc;
  logic [W_BITS-1:0]    wt_r [4];
  logic                 inside_r;

  assign fr   = quo_row[FRAC_BITS-1:0];
  assign fc   = quo_col[FRAC_BITS-1:0];
  assign fr_w = WT_BITS'(fr);
  assign fc_w = WT_BITS'(fc);
  assign omfr = WT_BITS'(ONE) - fr_w;
  assign omfc = WT_BITS'(ONE) - fc_w;

  always_ff @(posedge clk) begin
    if (ctl.chk) begin
      wt_r[0]  <= W_BITS'(omfr) * W_BITS'(omfc);
      wt_r[1]  <= W_BITS'(omfr) * W_BITS'(fc_w);
      wt_r[2]  <= W_BITS'(fr_w) * W_BITS'(omfc);
      wt_r[3]  <= W_BITS'(fr_w) * W_BITS'(fc_w);
      inside_r <= in_src;
    end
  end

  // Pixel memory: one port, written on store, read for the neighbors
  logic [PIXEL_BITS-1:0] mem [MEM_DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic [ADDR_BITS-1:0]  wr_addr, rd_addr, addr;
  logic [ADDR_BITS-1:0]  rd_row, rd_col;
  logic                  wr_ok;

  assign wr_addr = ADDR_BITS'(in_row) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(in_col);
  assign wr_ok   = (IDX_BITS'(in_row) < IDX_BITS'(MAX_HEIGHT)) &&
                   (IDX_BITS'(in_col) < IDX_BITS'(MAX_WIDTH));
  assign rd_row  = ADDR_BITS'(quo_row[NUM_BITS-1:FRAC_BITS]) + ADDR_BITS'(ctl.rd_sel[1]);
  assign rd_col  = ADDR_BITS'(quo_col[NUM_BITS-1:FRAC_BITS]) + ADDR_BITS'(ctl.rd_sel[0]);
  assign rd_addr = rd_row * ADDR_BITS'(MAX_WIDTH) + rd_col;
  assign addr    = ctl.store ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (ctl.store && wr_ok) begin
      mem[addr] <= {in_red_in, in_green_in, in_blue_in};
    end
    rd_data_r <= mem[addr];
  end

  // Blend sums: one neighbor per cycle, all three channels in parallel
  logic [ACC_BITS-1:0] acc_r [3];
  logic [ACC_BITS-1:0] acc_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc_nxt[k] = acc_r[k];
      if (ctl.chk) begin
        acc_nxt[k] = '0;
      end else if (ctl.mac_en) begin
        acc_nxt[k] = acc_r[k] +
                     ACC_BITS'(rd_data_r[k*CHAN_BITS +: CHAN_BITS]) *
                     ACC_BITS'(wt_r[ctl.mac_sel]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      acc_r[k] <= acc_nxt[k];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_blue_out   <= inside_r ? acc_r[0][2*FRAC_BITS +: CHAN_BITS] : '1;
      out_green_out  <= inside_r ? acc_r[1][2*FRAC_BITS +: CHAN_BITS] : '1;
      out_red_out    <= inside_r ? acc_r[2][2*FRAC_BITS +: CHAN_BITS] : '1;
      out_inside_res <= inside_r;
      out_out_width  <= size_w_r;
      out_out_height <= size_h_r;
    end
  end

endmodule

### hdl/bis_ctrl.sv
// Controller of the bilinear image scaler: sequences store, divide, neighbor
// reads and output handoff; owns the handshakes. Depends on bis_pkg.
module bis_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_cmd,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  bis_pkg::sts_t sts,
  output bis_pkg::ctl_t ctl
);
  import bis_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_LAST  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]               state_r, state_nxt;
  logic [STEP_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_STORE) begin
            ctl.store = 1'b1;
          end else begin
            ctl.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        cnt_nxt      = cnt_r + STEP_CNT_BITS'(1);
        if (cnt_r == STEP_CNT_BITS'(NUM_BITS - 1)) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ctl.chk   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = sts.in_src ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        ctl.rd_sel  = cnt_r[1:0];
        ctl.mac_en  = (cnt_r[1:0] != 2'd0);
        ctl.mac_sel = cnt_r[1:0] - 2'd1;
        cnt_nxt     = cnt_r + STEP_CNT_BITS'(1);
        if (cnt_r[1:0] == 2'd3) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        ctl.mac_en  = 1'b1;
        ctl.mac_sel = 2'd3;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/bis_checker.sv
// Port-level checker for the bilinear image scaler, bound to the top level.
// Depends on bis_pkg and bilinear_image_scaler_top.
module bis_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_cmd,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bis_pkg::CHAN_BITS-1:0] out_blue_out,
  input logic [bis_pkg::CHAN_BITS-1:0] out_green_out,
  input logic [bis_pkg::CHAN_BITS-1:0] out_red_out,
  input logic                          out_inside_res
);
  import bis_pkg::*;

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blue_out) &&
      $stable(out_green_out) && $stable(out_red_out) && $stable(out_inside_res))
    else $error("output word changed while stalled");

  // Outside pixels are white
  a_outside_white: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_blue_out == 8'hFF &&
      out_green_out == 8'hFF && out_red_out == 8'hFF)
    else $error("outside pixel not saturated");

  // A store word never raises an output
  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_STORE && !out_valid |=> !out_valid)
    else $error("store produced an output word");

  // A compute word blocks the input while it runs
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_COMPUTE |=> !in_ready)
    else $error("input taken during a compute");

endmodule

bind bilinear_image_scaler_top bis_checker u_bis_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_blue_out   (out_blue_out),
  .out_green_out  (out_green_out),
  .out_red_out    (out_red_out),
  .out_inside_res (out_inside_res)
);
